/* sv/srtf_pkg.sv */
// Shared types and constants for the shortest-remaining-time-first scheduler.
// Depends on nothing; imported by the scheduler top level.
`default_nettype none
package srtf_pkg;

    // Field widths fixed by the item format
    localparam int ID_W   = 8;
    localparam int TIME_W = 16;

    // Default table depth
    localparam int MAX_PROCESSES_DEF = 16;

    // Saturation value of the time counter
    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    // Item operation codes
    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_TICK = 1'b1
    } t_opcode;

    // One table entry as stored in the slot RAM
    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] arrival;
        logic [TIME_W-1:0] remaining;
    } t_slot;

    localparam int SLOT_W = $bits(t_slot);

endpackage
`default_nettype wire

/* sv/srtf_ram.sv */
// Generic single-write, single-read synchronous RAM with a registered read port.
// No dependencies.
`default_nettype none
module srtf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule
`default_nettype wire

/* sv/srtf_process_scheduler_unit.sv */
// Shortest-remaining-time-first process scheduler: slot table in a RAM, scanned per tick.
// Depends on srtf_pkg and srtf_ram.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+-------------------------------------------
//   in      | input     | i_in_valid / o_in_stall | opcode, process_id, arrival_time, burst_time
//   out     | output    | o_out_valid / i_out_stall | ran_id, idle, first_run, completed,
//           |           |                         | tick_time, all_done
//
// A load gives no result. A tick is accepted in idle, then the slot RAM read port
// delivers one entry per cycle to the minimum search, N being the number of loaded
// entries, then the drain state and the write-back state follow. With an empty table
// the scan and drain are skipped.
// Write-back waits while the previous result is still stalled in the output register.
// Synchronous active-low reset clears the entry count, done count, time and started flags.
`default_nettype none
module srtf_process_scheduler_unit #(
    parameter int MAX_PROCESSES = srtf_pkg::MAX_PROCESSES_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // input channel
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic                        i_opcode,
    input  wire logic [srtf_pkg::ID_W-1:0]   i_process_id,
    input  wire logic [srtf_pkg::TIME_W-1:0] i_arrival_time,
    input  wire logic [srtf_pkg::TIME_W-1:0] i_burst_time,
    // output channel
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic      [srtf_pkg::ID_W-1:0]   o_ran_id,
    output logic                             o_idle,
    output logic                             o_first_run,
    output logic                             o_completed,
    output logic      [srtf_pkg::TIME_W-1:0] o_tick_time,
    output logic                             o_all_done
);
    import srtf_pkg::*;

    localparam int IW = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
    localparam int CW = $clog2(MAX_PROCESSES + 1);
    localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_PROCESSES);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_WB
    } t_state;

    t_state            r_state;
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     r_done;
    logic [TIME_W-1:0] r_time;
    logic [MAX_PROCESSES-1:0] r_started;

    // scan pipeline
    logic [IW-1:0]     r_addr;
    logic              r_cmp_vld;
    logic [IW-1:0]     r_cmp_idx;
    logic              r_found;
    logic [IW-1:0]     r_best_idx;
    t_slot             r_best;

    t_slot             rd_slot;
    t_slot             wr_slot;
    logic              wr_en;
    logic [IW-1:0]     wr_addr;
    logic              in_xfer;
    logic              load_ok;
    logic              take;
    logic              wb_go;
    logic              fin;
    logic [CW-1:0]     n_done;
    logic [TIME_W-1:0] n_time;

    assign o_in_stall = (r_state != ST_IDLE);
    assign in_xfer    = i_in_valid && !o_in_stall;
    assign load_ok    = in_xfer && (t_opcode'(i_opcode) == OP_LOAD) && (r_count < COUNT_MAX);

    // candidate test on the entry just read
    assign take = r_cmp_vld && (rd_slot.arrival <= r_time) && (rd_slot.remaining != '0)
                  && (!r_found || (rd_slot.remaining < r_best.remaining));

    // write-back of the chosen entry, once the output register is free
    assign wb_go  = (r_state == ST_WB) && (!o_out_valid || !i_out_stall);
    assign fin    = r_found && (r_best.remaining == TIME_W'(1));
    assign n_done = fin ? r_done + CW'(1) : r_done;
    assign n_time = (r_time == TIME_MAX) ? r_time : r_time + TIME_W'(1);

    // RAM write mux: loads in idle, decremented entry at write-back
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_best_idx;
        wr_slot = r_best;
        wr_slot.remaining = r_best.remaining - TIME_W'(1);
        if (load_ok) begin
            wr_en             = 1'b1;
            wr_addr           = r_count[IW-1:0];
            wr_slot.id        = i_process_id;
            wr_slot.arrival   = i_arrival_time;
            wr_slot.remaining = i_burst_time;
        end else if (wb_go && r_found) begin
            wr_en = 1'b1;
        end
    end

    srtf_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (MAX_PROCESSES)
    ) u_slot_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_slot),
        .i_rd_en   (r_state == ST_SCAN),
        .i_rd_addr (r_addr),
        .o_rd_data (rd_slot)
    );

    // Sequence loads and ticks, hold scan state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_done      <= '0;
            r_time      <= '0;
            r_started   <= '0;
            r_cmp_vld   <= 1'b0;
            r_found     <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            // drop the result once transferred, unless a new one takes its place
            if (o_out_valid && !i_out_stall && !wb_go) begin
                o_out_valid <= 1'b0;
            end

            r_cmp_vld <= (r_state == ST_SCAN);
            r_cmp_idx <= r_addr;

            // advance the running minimum
            if (take) begin
                r_found    <= 1'b1;
                r_best_idx <= r_cmp_idx;
                r_best     <= rd_slot;
            end

            case (r_state)
                ST_IDLE: begin
                    if (load_ok) begin
                        r_started[r_count[IW-1:0]] <= 1'b0;
                        r_count <= r_count + CW'(1);
                        if (i_burst_time == '0) begin
                            r_done <= r_done + CW'(1);
                        end
                    end
                    if (in_xfer && (t_opcode'(i_opcode) == OP_TICK)) begin
                        r_found <= 1'b0;
                        r_addr  <= '0;
                        r_state <= (r_count == '0) ? ST_WB : ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (CW'(r_addr) + CW'(1) == r_count) begin
                        r_state <= ST_DRAIN;
                    end else begin
                        r_addr <= r_addr + IW'(1);
                    end
                end
                ST_DRAIN: begin
                    r_state <= ST_WB;
                end
                ST_WB: begin
                    if (wb_go) begin
                        if (r_found) begin
                            r_started[r_best_idx] <= 1'b1;
                        end
                        r_done      <= n_done;
                        r_time      <= n_time;
                        o_out_valid <= 1'b1;
                        o_ran_id    <= r_found ? r_best.id : '0;
                        o_idle      <= !r_found;
                        o_first_run <= r_found && !r_started[r_best_idx];
                        o_completed <= fin;
                        o_tick_time <= n_time;
                        o_all_done  <= (n_done >= r_count);
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire
